@@ rtl/core/enu_to_azimuth_elevation_macros.svh @@
// Assertion macros for the ENU to azimuth/elevation block.
// Used by the port checker; needs clk and rst_n in scope where expanded.
`ifndef ENU_TO_AZIMUTH_ELEVATION_MACROS_SVH
`define ENU_TO_AZIMUTH_ELEVATION_MACROS_SVH

// Same-cycle implication, held off during reset
`define E2AE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define E2AE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/e2ae_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// ENU to azimuth/elevation block. No dependencies.
`timescale 1ns / 1ps

package e2ae_pkg;

    // Datapath widths
    localparam int IN_W   = 32;   // width of one input component
    localparam int CALC_W = 64;   // CORDIC x/y width
    localparam int SCALE_POS = 60; // components are scaled up to this bit
    localparam int ANG_W  = 36;   // angle accumulator, 2^-24 degree units

    // Output angles, degrees * 65536
    localparam logic [24:0] AZ_EAST  = 25'd5898240;
    localparam logic [24:0] AZ_SOUTH = 25'd11796480;
    localparam logic [24:0] AZ_WEST  = 25'd17694720;
    localparam logic [24:0] AZ_FULL  = 25'd23592960;
    localparam logic signed [23:0] EL_UP   = 24'sd5898240;
    localparam logic signed [23:0] EL_DOWN = -24'sd5898240;

    // Fine angles, degrees * 2^24
    localparam logic signed [ANG_W-1:0] ANG180_FINE = 36'sd3019898880;
    localparam logic signed [ANG_W-1:0] ANG360_FINE = 36'sd6039797760;
    localparam logic signed [ANG_W-1:0] ROUND_FINE  = 36'sd128;

    // 1/K * 2^30 and the half-LSB used when rounding the gain product
    localparam logic [29:0] INV_GAIN    = 30'd652032874;
    localparam logic [62:0] GAIN_ROUND  = 63'd536870912;

    typedef struct packed {
        logic signed [IN_W-1:0] east;
        logic signed [IN_W-1:0] north;
        logic signed [IN_W-1:0] up;
    } enu_t;

    typedef struct packed {
        logic [24:0]        azimuth;
        logic signed [23:0] elevation;
        logic               azimuth_undefined;
    } angles_t;

    // Outcome of classification: which angles are fixed ahead of time
    typedef struct packed {
        logic               az_force;
        logic [24:0]        az_value;
        logic               el_force;
        logic signed [23:0] el_value;
        logic               undef;
    } cls_t;

    // One classified item, also the azimuth pipeline stage contents
    typedef struct packed {
        logic signed [CALC_W-1:0] x;
        logic signed [CALC_W-1:0] y;
        logic signed [ANG_W-1:0]  a;
        logic signed [CALC_W-1:0] u;
        cls_t                     cls;
    } item_t;

    // Elevation pipeline stage contents
    typedef struct packed {
        logic signed [CALC_W-1:0] x;
        logic signed [CALC_W-1:0] y;
        logic signed [ANG_W-1:0]  a;
        logic [24:0]              az;
        cls_t                     cls;
    } el_stage_t;

    // atan(2^-i) in 2^-24 degree units, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_fine(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 36'sd754974720;
            1:  v = 36'sd445687602;
            2:  v = 36'sd235489088;
            3:  v = 36'sd119537938;
            4:  v = 36'sd60000934;
            5:  v = 36'sd30029717;
            6:  v = 36'sd15018523;
            7:  v = 36'sd7509720;
            8:  v = 36'sd3754917;
            9:  v = 36'sd1877466;
            10: v = 36'sd938734;
            11: v = 36'sd469367;
            12: v = 36'sd234684;
            13: v = 36'sd117342;
            14: v = 36'sd58671;
            15: v = 36'sd29335;
            16: v = 36'sd14668;
            17: v = 36'sd7334;
            18: v = 36'sd3667;
            19: v = 36'sd1833;
            20: v = 36'sd917;
            21: v = 36'sd458;
            22: v = 36'sd229;
            23: v = 36'sd115;
            24: v = 36'sd57;
            25: v = 36'sd29;
            26: v = 36'sd14;
            27: v = 36'sd7;
            28: v = 36'sd4;
            29: v = 36'sd2;
            30: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/core/e2ae_queue.sv @@
// Two-entry register queue, used between front and back and on the result side.
// No package dependencies.
`timescale 1ns / 1ps

module e2ae_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_wr;
    logic         do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ rtl/core/e2ae_front.sv @@
// Front end: sign-extends and scales the components, picks the CORDIC
// start point and classifies axis and degenerate cases. Uses e2ae_pkg.
`timescale 1ns / 1ps

module e2ae_front #(
    parameter int COORD_WIDTH = 32
) (
    input  e2ae_pkg::enu_t  enu,
    output e2ae_pkg::item_t item
);

    localparam int GUARD = e2ae_pkg::SCALE_POS - COORD_WIDTH;

    logic signed [e2ae_pkg::CALC_W-1:0] e_val;
    logic signed [e2ae_pkg::CALC_W-1:0] n_val;
    logic signed [e2ae_pkg::CALC_W-1:0] u_val;
    logic signed [e2ae_pkg::CALC_W-1:0] e_s;
    logic signed [e2ae_pkg::CALC_W-1:0] n_s;
    logic e_zero;
    logic n_zero;
    logic u_zero;
    logic undef;

    // Low COORD_WIDTH bits of the field, two's complement, widened
    function automatic logic signed [e2ae_pkg::CALC_W-1:0] widen(
        input logic [e2ae_pkg::IN_W-1:0] f
    );
        logic [e2ae_pkg::CALC_W-1:0] raw;
        logic [COORD_WIDTH-1:0]      m;
        raw = {{(e2ae_pkg::CALC_W - e2ae_pkg::IN_W){1'b0}}, f};
        m   = raw[COORD_WIDTH-1:0];
        return $signed({{(e2ae_pkg::CALC_W - COORD_WIDTH){m[COORD_WIDTH-1]}}, m});
    endfunction

    assign e_val  = widen(enu.east);
    assign n_val  = widen(enu.north);
    assign u_val  = widen(enu.up);
    assign e_s    = e_val <<< GUARD;
    assign n_s    = n_val <<< GUARD;
    assign e_zero = (e_val == '0);
    assign n_zero = (n_val == '0);
    assign u_zero = (u_val == '0);
    assign undef  = e_zero && n_zero;

    // Start point and classification of exact angles
    always_comb
    begin
        // Left half-plane is mirrored and starts at 180 degrees
        item.u = u_val <<< GUARD;
        if (n_val < 0)
        begin
            item.x = -n_s;
            item.y = -e_s;
            item.a = e2ae_pkg::ANG180_FINE;
        end
        else
        begin
            item.x = n_s;
            item.y = e_s;
            item.a = '0;
        end

        // Exact azimuth on the axes, exact elevation when level or vertical
        item.cls.undef    = undef;
        item.cls.az_force = e_zero || n_zero;
        if (undef)
        begin
            item.cls.az_value = '0;
        end
        else if (n_zero)
        begin
            item.cls.az_value = (e_val > 0) ? e2ae_pkg::AZ_EAST : e2ae_pkg::AZ_WEST;
        end
        else if (e_zero)
        begin
            item.cls.az_value = (n_val > 0) ? '0 : e2ae_pkg::AZ_SOUTH;
        end
        else
        begin
            item.cls.az_value = '0;
        end

        item.cls.el_force = undef || u_zero;
        if (undef && (u_val > 0))
        begin
            item.cls.el_value = e2ae_pkg::EL_UP;
        end
        else if (undef && (u_val < 0))
        begin
            item.cls.el_value = e2ae_pkg::EL_DOWN;
        end
        else
        begin
            item.cls.el_value = '0;
        end
    end

endmodule

@@ rtl/core/e2ae_back.sv @@
// Back end: azimuth CORDIC pipeline, gain correction, elevation CORDIC
// pipeline and output rounding. Uses e2ae_pkg.
`timescale 1ns / 1ps

module e2ae_back #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  e2ae_pkg::item_t   item,
    input  logic              item_valid,
    output logic              take,
    input  logic              out_full,
    output e2ae_pkg::angles_t res,
    output logic              res_valid
);

    localparam int N = CORDIC_STAGES;
    localparam int AW = e2ae_pkg::ANG_W;

    typedef struct packed {
        logic signed [AW-1:0]               a;
        logic [61:0]                        ph;
        logic [61:0]                        pl;
        logic signed [e2ae_pkg::CALC_W-1:0] u;
        e2ae_pkg::cls_t                     cls;
    } post_t;

    e2ae_pkg::item_t     az_reg [N];
    e2ae_pkg::el_stage_t el_reg [N];
    post_t               p1_reg;
    post_t               p1_next;
    e2ae_pkg::el_stage_t p2_reg;
    e2ae_pkg::el_stage_t p2_next;
    e2ae_pkg::angles_t   fin_reg;
    e2ae_pkg::angles_t   fin_next;

    logic [N-1:0] az_vld_reg;
    logic [N-1:0] el_vld_reg;
    logic         p1_vld_reg;
    logic         p2_vld_reg;
    logic         fin_vld_reg;
    logic         adv;

    // Whole pipeline holds only when a finished result cannot leave
    assign adv       = !(out_full && fin_vld_reg);
    assign take      = adv && item_valid;
    assign res_valid = adv && fin_vld_reg;
    assign res       = fin_reg;

    // Azimuth vectoring, one micro-rotation per stage
    for (genvar k = 0; k < N; k++)
    begin : g_az
        e2ae_pkg::item_t s_in;
        e2ae_pkg::item_t s_next;
        if (k == 0)
        begin : g_first
            assign s_in = item;
        end
        else
        begin : g_rest
            assign s_in = az_reg[k-1];
        end

        always_comb
        begin
            s_next = s_in;
            if (s_in.y >= 0)
            begin
                s_next.x = s_in.x + (s_in.y >>> k);
                s_next.y = s_in.y - (s_in.x >>> k);
                s_next.a = s_in.a + e2ae_pkg::atan_fine(k);
            end
            else
            begin
                s_next.x = s_in.x - (s_in.y >>> k);
                s_next.y = s_in.y + (s_in.x >>> k);
                s_next.a = s_in.a - e2ae_pkg::atan_fine(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                az_reg[k] <= s_next;
            end
        end
    end

    // Post 1: wrap negative angle and add rounding; split gain product
    always_comb
    begin
        logic signed [AW-1:0] a_end;
        logic [31:0]          xf_hi;
        logic [31:0]          xf_lo;
        a_end      = az_reg[N-1].a;
        xf_hi      = az_reg[N-1].x[63:32];
        xf_lo      = az_reg[N-1].x[31:0];
        p1_next.a  = a_end + ((a_end < 0) ?
                     (e2ae_pkg::ANG360_FINE + e2ae_pkg::ROUND_FINE) : e2ae_pkg::ROUND_FINE);
        p1_next.ph = xf_hi * e2ae_pkg::INV_GAIN;
        p1_next.pl = xf_lo * e2ae_pkg::INV_GAIN;
        p1_next.u  = az_reg[N-1].u;
        p1_next.cls = az_reg[N-1].cls;
    end

    // Post 2: final azimuth, horizontal length, elevation start point
    always_comb
    begin
        logic [24:0] az_raw;
        logic [24:0] az_wrap;
        logic [62:0] lo_sum;
        logic [63:0] h;
        az_raw  = p1_reg.a[32:8];
        az_wrap = (az_raw >= e2ae_pkg::AZ_FULL) ? (az_raw - e2ae_pkg::AZ_FULL) : az_raw;
        lo_sum  = {1'b0, p1_reg.pl} + e2ae_pkg::GAIN_ROUND;
        h       = {p1_reg.ph, 2'b00} + {31'b0, lo_sum[62:30]};
        p2_next.x   = $signed(h);
        p2_next.y   = p1_reg.u;
        p2_next.a   = '0;
        p2_next.az  = p1_reg.cls.az_force ? p1_reg.cls.az_value : az_wrap;
        p2_next.cls = p1_reg.cls;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg <= p1_next;
            p2_reg <= p2_next;
        end
    end

    // Elevation vectoring, one micro-rotation per stage
    for (genvar k = 0; k < N; k++)
    begin : g_el
        e2ae_pkg::el_stage_t s_in;
        e2ae_pkg::el_stage_t s_next;
        if (k == 0)
        begin : g_first
            assign s_in = p2_reg;
        end
        else
        begin : g_rest
            assign s_in = el_reg[k-1];
        end

        always_comb
        begin
            s_next = s_in;
            if (s_in.y >= 0)
            begin
                s_next.x = s_in.x + (s_in.y >>> k);
                s_next.y = s_in.y - (s_in.x >>> k);
                s_next.a = s_in.a + e2ae_pkg::atan_fine(k);
            end
            else
            begin
                s_next.x = s_in.x - (s_in.y >>> k);
                s_next.y = s_in.y + (s_in.x >>> k);
                s_next.a = s_in.a - e2ae_pkg::atan_fine(k);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                el_reg[k] <= s_next;
            end
        end
    end

    // Final: round elevation, clamp to +-90, apply fixed cases
    always_comb
    begin
        logic signed [AW:0]   el_sum;
        logic signed [AW-8:0] el_r;
        el_sum = (AW+1)'(el_reg[N-1].a) + (AW+1)'(e2ae_pkg::ROUND_FINE);
        el_r   = el_sum[AW:8];
        fin_next.azimuth           = el_reg[N-1].az;
        fin_next.azimuth_undefined = el_reg[N-1].cls.undef;
        if (el_reg[N-1].cls.el_force)
        begin
            fin_next.elevation = el_reg[N-1].cls.el_value;
        end
        else if (el_r > (AW-7)'(e2ae_pkg::EL_UP))
        begin
            fin_next.elevation = e2ae_pkg::EL_UP;
        end
        else if (el_r < (AW-7)'(e2ae_pkg::EL_DOWN))
        begin
            fin_next.elevation = e2ae_pkg::EL_DOWN;
        end
        else
        begin
            fin_next.elevation = el_r[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg <= fin_next;
        end
    end

    // Valid bits follow the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_vld_reg  <= '0;
            el_vld_reg  <= '0;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            az_vld_reg  <= {az_vld_reg[N-2:0], item_valid};
            p1_vld_reg  <= az_vld_reg[N-1];
            p2_vld_reg  <= p1_vld_reg;
            el_vld_reg  <= {el_vld_reg[N-2:0], p2_vld_reg};
            fin_vld_reg <= el_vld_reg[N-1];
        end
    end

endmodule

@@ rtl/core/enu_to_azimuth_elevation.sv @@
// Top level of the ENU to azimuth/elevation block.
// Depends on e2ae_pkg, e2ae_front, e2ae_queue and e2ae_back.
//
//  channel   handshake               payload
//  input     push / full             enu    (east, north, up)
//  result    empty / pop             angles (azimuth, elevation, azimuth_undefined)
//
// One vector enters per cycle while full is low; results pass through the two CORDIC
// pipelines, each of one micro-rotation per stage.
// Reset clears the queue pointers and counts and the pipeline valid bits only.
// A full result queue with a result waiting at the pipeline end holds the back end;
// the input side keeps taking vectors until the two-entry queue before the back end fills.
`timescale 1ns / 1ps

module enu_to_azimuth_elevation #(
    parameter int COORD_WIDTH   = 32,
    parameter int CORDIC_STAGES = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  e2ae_pkg::enu_t    enu,
    output logic              empty,
    input  logic              pop,
    output e2ae_pkg::angles_t angles
);

    localparam int ITEM_W = $bits(e2ae_pkg::item_t);
    localparam int RES_W  = $bits(e2ae_pkg::angles_t);

    e2ae_pkg::item_t   front_item;
    logic [ITEM_W-1:0] mid_data;
    logic              mid_empty;
    logic              mid_take;
    e2ae_pkg::angles_t back_res;
    logic              back_res_valid;
    logic              out_full;
    logic [RES_W-1:0]  out_data;

    e2ae_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .enu  (enu),
        .item (front_item)
    );

    // Queue between classification and the CORDIC back end
    e2ae_queue #(
        .W (ITEM_W)
    ) u_mid_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (front_item),
        .full    (full),
        .rd_en   (mid_take),
        .rd_data (mid_data),
        .empty   (mid_empty)
    );

    e2ae_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (mid_data),
        .item_valid (!mid_empty),
        .take       (mid_take),
        .out_full   (out_full),
        .res        (back_res),
        .res_valid  (back_res_valid)
    );

    // Result queue facing the consumer
    e2ae_queue #(
        .W (RES_W)
    ) u_out_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (back_res_valid),
        .wr_data (back_res),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_data),
        .empty   (empty)
    );

    assign angles = out_data;

endmodule

@@ rtl/core/e2ae_checker.sv @@
// Port-level checker for enu_to_azimuth_elevation, bound to the top level.
// Depends on e2ae_pkg and enu_to_azimuth_elevation_macros.svh.
`timescale 1ns / 1ps
`include "enu_to_azimuth_elevation_macros.svh"

module e2ae_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input e2ae_pkg::angles_t angles
);

    logic el_in_range;

    // Elevation bounds of the waiting result
    assign el_in_range = (angles.elevation <= e2ae_pkg::EL_UP)
                      && (angles.elevation >= e2ae_pkg::EL_DOWN);

    // Azimuth stays below a full turn
    `E2AE_ASSERT_NOW(a_az_range, !empty, angles.azimuth < e2ae_pkg::AZ_FULL, "azimuth out of range")

    // Elevation stays within +-90 degrees
    `E2AE_ASSERT_NOW(a_el_range, !empty, el_in_range, "elevation out of range")

    // An undefined azimuth is reported as zero
    `E2AE_ASSERT_NOW(a_undef_zero, !empty && angles.azimuth_undefined, angles.azimuth == '0, "undefined azimuth not zero")

    // A waiting result holds until it is taken
    `E2AE_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty && $stable(angles), "result changed while waiting")

endmodule

bind enu_to_azimuth_elevation e2ae_checker u_checker (.*);

@@ tb/sv/tb.sv @@
// Self-checking testbench for enu_to_azimuth_elevation: directed and random ENU vectors,
// checked against a bit-exact CORDIC azimuth/elevation predictor under varied flow control.
// Depends on e2ae_pkg and the enu_to_azimuth_elevation RTL.
`timescale 1ns / 1ps

module tb;

    localparam int COORD_W   = 32;
    localparam int STAGES    = 24;
    localparam int LATENCY   = 2 * STAGES + 4;
    localparam int SHIFT_UP  = e2ae_pkg::SCALE_POS - COORD_W;
    localparam int MAX_CYCLES = 200000;
    localparam int SHOW_LIMIT = 10;

    localparam logic [31:0] C_MAX = 32'h7fffffff;
    localparam logic [31:0] C_MIN = 32'h80000000;

    // Fine-angle constants, degrees * 2^24, and output angles, degrees * 65536
    localparam longint HALF_TURN_FINE = 64'sd3019898880;
    localparam longint FULL_TURN_FINE = 64'sd6039797760;
    localparam longint QUARTER_OUT    = 64'sd5898240;
    localparam longint HALF_OUT       = 64'sd11796480;
    localparam longint THREE_Q_OUT    = 64'sd17694720;
    localparam longint FULL_OUT       = 64'sd23592960;
    localparam logic [63:0] RECIP_GAIN = 64'd652032874;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              push  = 1'b0;
    logic              pop   = 1'b0;
    e2ae_pkg::enu_t    enu   = '0;
    logic              full;
    logic              empty;
    e2ae_pkg::angles_t angles;

    e2ae_pkg::angles_t angles_due[$];
    e2ae_pkg::angles_t head_angles;
    int      mismatches    = 0;
    int      send_idle_pct = 0;
    int      pop_stall_pct = 0;
    int      hold_left     = 0;
    int      cycles        = 0;

    // atan(2^-i) in 2^-24 degree units
    longint  atan_step [STAGES] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    enu_to_azimuth_elevation #(
        .COORD_WIDTH   (COORD_W),
        .CORDIC_STAGES (STAGES)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .enu    (enu),
        .empty  (empty),
        .pop    (pop),
        .angles (angles)
    );

    always #5 clk = ~clk;

    // Vectoring CORDIC: drives y to zero, returns the accumulated angle
    function automatic longint cordic_vector(input longint x_in, input longint y_in,
                                             input longint a_in, output longint x_out);
        longint x;
        longint y;
        longint a;
        longint dx;
        longint dy;
        x = x_in;
        y = y_in;
        a = a_in;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + atan_step[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - atan_step[i];
            end
        end
        x_out = x;
        return a;
    endfunction

    // Expected azimuth/elevation for one vector
    function automatic e2ae_pkg::angles_t predict_angles(input e2ae_pkg::enu_t v);
        e2ae_pkg::angles_t res;
        longint     e;
        longint     n;
        longint     u;
        longint     a;
        longint     az;
        longint     el;
        longint     x_az;
        longint     x_el;
        logic [63:0] hu;
        logic [63:0] horiz;
        e  = longint'(v.east);
        n  = longint'(v.north);
        u  = longint'(v.up);
        az = 0;
        el = 0;
        res.azimuth_undefined = 1'b0;
        if (e == 0 && n == 0)
        begin
            // no horizontal part: straight up, straight down or zero
            res.azimuth_undefined = 1'b1;
            el = (u > 0) ? QUARTER_OUT : ((u < 0) ? -QUARTER_OUT : 0);
        end
        else
        begin
            // southern half is turned by 180 so x starts non-negative
            if (n < 0)
                a = cordic_vector(-n <<< SHIFT_UP, -e <<< SHIFT_UP, HALF_TURN_FINE, x_az);
            else
                a = cordic_vector(n <<< SHIFT_UP, e <<< SHIFT_UP, 0, x_az);
            if (a < 0)
                a = a + FULL_TURN_FINE;
            az = (a + 128) >>> 8;
            if (az >= FULL_OUT)
                az = az - FULL_OUT;
            if (n == 0)
                az = (e > 0) ? QUARTER_OUT : THREE_Q_OUT;
            else if (e == 0)
                az = (n > 0) ? 0 : HALF_OUT;

            // remove CORDIC gain from the horizontal length, split product
            hu    = x_az;
            horiz = (hu >> 32) * RECIP_GAIN * 64'd4
                  + (((hu & 64'hffffffff) * RECIP_GAIN + (64'd1 << 29)) >> 30);

            if (u != 0)
            begin
                a  = cordic_vector(longint'(horiz), u <<< SHIFT_UP, 0, x_el);
                el = (a + 128) >>> 8;
                if (el > QUARTER_OUT)
                    el = QUARTER_OUT;
                if (el < -QUARTER_OUT)
                    el = -QUARTER_OUT;
            end
        end
        res.azimuth   = az[24:0];
        res.elevation = el[23:0];
        return res;
    endfunction

    function automatic e2ae_pkg::enu_t vec(input logic [31:0] e, input logic [31:0] n,
                                           input logic [31:0] u);
        e2ae_pkg::enu_t v;
        v.east  = e;
        v.north = n;
        v.up    = u;
        return v;
    endfunction

    // Mix of full-range, small, extreme, shifted and zero components
    function automatic logic [31:0] random_coord();
        logic [31:0] r;
        int          s;
        r = $urandom();
        s = $urandom_range(8);
        case ($urandom_range(5))
            0: r = s - 4;
            1:
            begin
                case ($urandom_range(4))
                    0: r = C_MAX;
                    1: r = C_MIN;
                    2: r = 32'd1;
                    3: r = 32'hffffffff;
                    default: r = C_MIN + 32'd1;
                endcase
            end
            2: r = $signed(r) >>> $urandom_range(31);
            3: r = '0;
            default: ;
        endcase
        return r;
    endfunction

    // Offer one vector, wait for its transfer, then maybe idle a while
    task automatic send_vector(input e2ae_pkg::enu_t v);
        @(negedge clk);
        push <= 1'b1;
        enu  <= v;
        @(posedge clk);
        while (full)
            @(posedge clk);
        angles_due.push_back(predict_angles(v));
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
    endtask

    task automatic wait_all_results();
        while (angles_due.size() != 0)
            @(posedge clk);
    endtask

    // Zero vector, axes, extremes, level vectors, wrap at 360, elevation clamp
    task automatic test_directed_cases();
        send_vector(vec(0, 0, 0));
        send_vector(vec(0, 0, 5));
        send_vector(vec(0, 0, -5));
        send_vector(vec(0, 0, C_MAX));
        send_vector(vec(0, 0, C_MIN));
        send_vector(vec(7, 0, 0));
        send_vector(vec(-7, 0, 3));
        send_vector(vec(0, 9, -2));
        send_vector(vec(0, -9, 1));
        send_vector(vec(C_MAX, C_MAX, C_MAX));
        send_vector(vec(C_MIN, C_MIN, C_MIN));
        send_vector(vec(C_MAX, C_MIN, 0));
        send_vector(vec(C_MIN, C_MAX, 1));
        send_vector(vec(0, C_MIN, 0));
        send_vector(vec(C_MIN, 0, C_MAX));
        send_vector(vec(-1, C_MAX, 0));
        send_vector(vec(-1, 1000000, 0));
        send_vector(vec(1, 0, C_MAX));
        send_vector(vec(1, 1, C_MIN));
        send_vector(vec(-1, -1, C_MIN));
        send_vector(vec(3, 4, 0));
        send_vector(vec(100, -100, 50));
        send_vector(vec(-100, -100, -50));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        send_idle_pct = idle_pct;
        pop_stall_pct = stall_pct;
        repeat (count)
            send_vector(vec(random_coord(), random_coord(), random_coord()));
    endtask

    // Result side holds off long enough for the block to fill and raise full
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_left = 300;
        repeat (80)
            send_vector(vec(random_coord(), random_coord(), random_coord()));
    endtask

    // Sender stops until every outstanding result has come back
    task automatic test_drain_pause();
        @(negedge clk);
        push <= 1'b0;
        wait_all_results();
        send_idle_pct = 0;
        pop_stall_pct = 37;
        repeat (20)
            send_vector(vec(random_coord(), random_coord(), random_coord()));
    endtask

    // Result side: long hold-off when requested, else random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("unexpected result: az %0d el %0d undef %0b",
                             angles.azimuth, angles.elevation, angles.azimuth_undefined);
            end
            else
            begin
                head_angles = angles_due.pop_front();
                if (angles.azimuth !== head_angles.azimuth
                    || angles.elevation !== head_angles.elevation
                    || angles.azimuth_undefined !== head_angles.azimuth_undefined)
                begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display({"mismatch: expected az %0d el %0d undef %0b, ",
                                  "got az %0d el %0d undef %0b"},
                                 head_angles.azimuth, head_angles.elevation,
                                 head_angles.azimuth_undefined, angles.azimuth,
                                 angles.elevation, angles.azimuth_undefined);
                end
            end
        end
    end

    // Run-time limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_random_traffic(0, 0, 85);
        test_random_traffic(88, 0, 80);
        test_random_traffic(0, 88, 80);
        test_random_traffic(37, 37, 80);
        test_output_backpressure();
        test_drain_pause();

        // let the pipeline empty, then look for stray results
        @(negedge clk);
        push <= 1'b0;
        pop_stall_pct = 0;
        wait_all_results();
        repeat (LATENCY + 8)
            @(posedge clk);
        if (angles_due.size() != 0)
            mismatches++;

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
